FILE: sv/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the integer to ASCII converter
// Holds the state type, the divider control and status structs, the
// character codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package ita_pkg;

   // Default width of the converted integer
   localparam int VALUE_BITS_DEFAULT = 32;

   // Radix register and character widths
   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 8;

   // Radix limits and the base that prints a sign
   localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_W-1:0] DECIMAL_BASE = 6'd10;
   localparam logic [RADIX_W-1:0] LAST_NUMERAL = 6'd9;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEGATE,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // Control from the sequencer to the serial divider
   typedef struct packed {
      logic load;
      logic negate_step;
      logic divide_step;
      logic digit_end;
   } div_ctrl_type;

   // Status from the serial divider
   typedef struct packed {
      logic [RADIX_W-1:0] digit;
      logic               more;
   } div_stat_type;

   // Map one digit value to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
      if (d > LAST_NUMERAL) begin
         return ext - LETTER_OFS + CHAR_A;
      end
      return ext + CHAR_ZERO;
   endfunction

endpackage

FILE: sv/ita_divider.sv
// ----------------------------------------------------------------------------
// ita_divider: bit-serial negation and restoring division by the radix
// Negates the word LSB first when asked, then divides it by the base one
// quotient bit per cycle, MSB first, leaving the quotient in place.
// ----------------------------------------------------------------------------
module ita_divider #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic [VALUE_BITS-1:0]        load_value,
   input  logic [ita_pkg::RADIX_W-1:0]  base,
   input  ita_pkg::div_ctrl_type        ctrl,
   output ita_pkg::div_stat_type        stat
);

   logic [VALUE_BITS-1:0]       mag_ff;
   logic [ita_pkg::RADIX_W-1:0] rem_ff;
   logic                        nz_ff;
   logic                        carry_ff;

   logic [ita_pkg::RADIX_W:0]   trial;
   logic [ita_pkg::RADIX_W:0]   base_ext;
   logic [ita_pkg::RADIX_W:0]   diff;
   logic                        ge;
   logic [ita_pkg::RADIX_W-1:0] rem_in;
   logic                        neg_bit;
   logic                        neg_carry;

   // Trial subtraction of the base from the shifted partial remainder
   always_comb begin
      trial    = {rem_ff, mag_ff[VALUE_BITS-1]};
      base_ext = {1'b0, base};
      ge       = (trial >= base_ext);
      diff     = trial - base_ext;
      rem_in   = ge ? diff[ita_pkg::RADIX_W-1:0] : trial[ita_pkg::RADIX_W-1:0];
   end

   // Two's complement one bit at a time: invert and add the running carry
   assign neg_bit   = ~mag_ff[0] ^ carry_ff;
   assign neg_carry = ~mag_ff[0] & carry_ff;

   // Advance the datapath
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff   <= load_value;
         rem_ff   <= '0;
         nz_ff    <= 1'b0;
         carry_ff <= 1'b1;
      end else if (ctrl.negate_step) begin
         mag_ff   <= {neg_bit, mag_ff[VALUE_BITS-1:1]};
         carry_ff <= neg_carry;
      end else if (ctrl.divide_step) begin
         mag_ff <= {mag_ff[VALUE_BITS-2:0], ge};
         if (ctrl.digit_end) begin
            rem_ff <= '0;
            nz_ff  <= 1'b0;
         end else begin
            rem_ff <= rem_in;
            nz_ff  <= nz_ff | ge;
         end
      end
   end

   // Report the finished remainder and whether the quotient is non-zero
   assign stat.digit = rem_in;
   assign stat.more  = nz_ff | ge;

endmodule

FILE: sv/integer_to_ascii_radix_top.sv
// Sequence: a negation pass for a negative decimal value, then a division pass
//   per digit, then one character a cycle.
// One number at a time: start is taken only in idle, and the bit-serial divider
//   works one quotient bit per cycle.
// The receiver cannot stall: each character strobes for exactly one cycle.
// Reset (synchronous, active high) returns to idle and sets the radix to ten.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top: integer to text in a base from 2 to 36
// Divides the value serially by the base, stacks the digits, then emits
// the sign and the digits most significant first, marking the last one.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [VALUE_BITS-1:0]       req_value,
   output logic                               rsp_valid,
   output logic [ita_pkg::CHAR_W-1:0]         rsp_character,
   output logic                               rsp_final_char,
   input  logic                               csr_write_enable,
   input  logic [ita_pkg::RADIX_W-1:0]        csr_write_data
);

   localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DEPTH_W   = $clog2(VALUE_BITS + 1);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_BITS - 1);
   localparam logic [DEPTH_W-1:0]   DEPTH_ONE = DEPTH_W'(1);

   ita_pkg::state_type          state_ff, state_in;
   logic [ita_pkg::RADIX_W-1:0] radix_ff;
   logic [ita_pkg::RADIX_W-1:0] base_ff;
   logic [ita_pkg::RADIX_W-1:0] eff_radix;
   logic                        negative_ff;
   logic                        negative_in;
   logic [BIT_CNT_W-1:0]        bit_cnt_ff;
   logic [DEPTH_W-1:0]          depth_ff;
   logic [ita_pkg::RADIX_W-1:0] stack_ff [VALUE_BITS];

   logic                        accept;
   logic                        bit_last;
   logic                        push;
   logic                        pop;
   ita_pkg::div_ctrl_type       div_ctrl;
   ita_pkg::div_stat_type       div_stat;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= ita_pkg::RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   // Clamp the radix to the working range
   always_comb begin
      priority if (radix_ff < ita_pkg::RADIX_MIN) begin
         eff_radix = ita_pkg::RADIX_MIN;
      end else if (radix_ff > ita_pkg::RADIX_MAX) begin
         eff_radix = ita_pkg::RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   assign accept      = start && (state_ff == ita_pkg::ST_IDLE);
   assign negative_in = (eff_radix == ita_pkg::DECIMAL_BASE) && req_value[VALUE_BITS-1];
   assign bit_last    = (bit_cnt_ff == BIT_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ita_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = negative_in ? ita_pkg::ST_NEGATE : ita_pkg::ST_DIVIDE;
            end
         end
         ita_pkg::ST_NEGATE: begin
            if (bit_last) begin
               state_in = ita_pkg::ST_DIVIDE;
            end
         end
         ita_pkg::ST_DIVIDE: begin
            if (bit_last && !div_stat.more) begin
               state_in = negative_ff ? ita_pkg::ST_SIGN : ita_pkg::ST_DIGITS;
            end
         end
         ita_pkg::ST_SIGN: begin
            state_in = ita_pkg::ST_DIGITS;
         end
         ita_pkg::ST_DIGITS: begin
            if (depth_ff == DEPTH_ONE) begin
               state_in = ita_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ita_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and divider control
   always_comb begin
      busy                 = 1'b1;
      rsp_valid            = 1'b0;
      rsp_character        = ita_pkg::digit_char(stack_ff[0]);
      rsp_final_char       = 1'b0;
      div_ctrl.load        = 1'b0;
      div_ctrl.negate_step = 1'b0;
      div_ctrl.divide_step = 1'b0;
      div_ctrl.digit_end   = bit_last;
      push                 = 1'b0;
      pop                  = 1'b0;
      unique case (state_ff)
         ita_pkg::ST_IDLE: begin
            busy          = 1'b0;
            div_ctrl.load = accept;
         end
         ita_pkg::ST_NEGATE: begin
            div_ctrl.negate_step = 1'b1;
         end
         ita_pkg::ST_DIVIDE: begin
            div_ctrl.divide_step = 1'b1;
            push                 = bit_last;
         end
         ita_pkg::ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_character = ita_pkg::CHAR_MINUS;
         end
         ita_pkg::ST_DIGITS: begin
            rsp_valid      = 1'b1;
            rsp_final_char = (depth_ff == DEPTH_ONE);
            pop            = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ita_pkg::ST_IDLE;
         bit_cnt_ff  <= '0;
         depth_ff    <= '0;
         negative_ff <= 1'b0;
         base_ff     <= ita_pkg::RADIX_RESET;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            bit_cnt_ff  <= '0;
            depth_ff    <= '0;
            negative_ff <= negative_in;
            base_ff     <= eff_radix;
         end else begin
            // Step the bit counter through each pass
            if (div_ctrl.negate_step || div_ctrl.divide_step) begin
               bit_cnt_ff <= bit_last ? '0 : bit_cnt_ff + BIT_CNT_W'(1);
            end
            if (push) begin
               depth_ff <= depth_ff + DEPTH_W'(1);
            end else if (pop) begin
               depth_ff <= depth_ff - DEPTH_W'(1);
            end
         end
      end
   end

   // Digit stack: push at the bottom while dividing, pop from the bottom while emitting
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[0] <= div_stat.digit;
         for (int i = 1; i < VALUE_BITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   // Serial divider
   ita_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock      (clock),
      .load_value (req_value),
      .base       (base_ff),
      .ctrl       (div_ctrl),
      .stat       (div_stat)
   );

endmodule

FILE: dv/tb_integer_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_top: self-checking bench for the radix converter
// Drives numbers through the start/busy command port under several radix
// settings, predicts the text of each number in the bench and compares every
// strobed character and its last-character flag in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_top;

   localparam int VW          = ita_pkg::VALUE_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int IDLE_PCT    = 6;
   localparam int MAX_LINES   = 100;

   typedef struct packed {
      logic [ita_pkg::CHAR_W-1:0] code;
      logic                       last;
   } text_char_type;

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           start            = 1'b0;
   logic                           busy;
   logic signed [VW-1:0]           req_value        = '0;
   logic                           rsp_valid;
   logic [ita_pkg::CHAR_W-1:0]     rsp_character;
   logic                           rsp_final_char;
   logic                           csr_write_enable = 1'b0;
   logic [ita_pkg::RADIX_W-1:0]    csr_write_data   = '0;

   text_char_type                  expected_text[$];
   text_char_type                  next_char;
   logic [ita_pkg::RADIX_W-1:0]    radix_setting = ita_pkg::RADIX_RESET;
   int                             mismatch_count = 0;
   int                             cycle_count = 0;
   int                             char_count = 0;
   bit                             quiet_sender = 1'b0;

   integer_to_ascii_radix_top #(
      .VALUE_BITS(VW)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_final_char   (rsp_final_char),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run if the traffic never drains
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Print one line per mismatch, up to a cap, and count them all
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_LINES) begin
         $display("[%0t] mismatch on character %0d: %s", $time, char_count, what);
      end
      mismatch_count++;
   endtask

   // Work out the text of one number under the given radix register value
   // and queue its characters, most significant first
   function automatic void queue_number_text(input logic [VW-1:0] word,
                                             input logic [ita_pkg::RADIX_W-1:0] reg_radix);
      logic [ita_pkg::RADIX_W-1:0] base;
      logic [VW-1:0]               mag;
      logic [VW-1:0]               digit;
      logic [ita_pkg::CHAR_W-1:0]  reversed[$];
      bit                          negative;
      int                          k;
      if (reg_radix < ita_pkg::RADIX_MIN) begin
         base = ita_pkg::RADIX_MIN;
      end else if (reg_radix > ita_pkg::RADIX_MAX) begin
         base = ita_pkg::RADIX_MAX;
      end else begin
         base = reg_radix;
      end
      // Only base ten reads the word as signed
      negative = (base == ita_pkg::DECIMAL_BASE) && word[VW-1];
      mag      = negative ? (~word + 1'b1) : word;
      if (word == '0) begin
         reversed.push_back(ita_pkg::CHAR_ZERO);
      end
      while (mag != '0) begin
         digit = mag % base;
         if (digit > ita_pkg::LAST_NUMERAL) begin
            reversed.push_back(ita_pkg::CHAR_A + ita_pkg::CHAR_W'(digit) - ita_pkg::LETTER_OFS);
         end else begin
            reversed.push_back(ita_pkg::CHAR_ZERO + ita_pkg::CHAR_W'(digit));
         end
         mag = mag / base;
      end
      if (negative) begin
         reversed.push_back(ita_pkg::CHAR_MINUS);
      end
      for (k = reversed.size() - 1; k >= 0; k--) begin
         expected_text.push_back('{code: reversed[k], last: (k == 0)});
      end
   endfunction

   // Random sender gap: none in a quiet stretch, otherwise a short geometric run
   function automatic int sender_gap();
      int n;
      n = 0;
      if (!quiet_sender) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            n++;
         end
      end
      return n;
   endfunction

   // Send one number and queue its expected text once the transaction is taken
   task automatic send_number(input logic [VW-1:0] word);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
      queue_number_text(word, radix_setting);
   endtask

   // Hold off until every expected character has arrived and the block is idle
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0 || busy !== 1'b0);
   endtask

   // Write the radix register while the block is idle
   task automatic write_radix(input logic [ita_pkg::RADIX_W-1:0] r);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= r;
      @(posedge clock);
      radix_setting = r;
      csr_write_enable <= 1'b0;
   endtask

   // Draw a value: full and shifted-down words, with small, negative and boundary ones mixed in
   function automatic logic [VW-1:0] random_value();
      logic [VW-1:0] v;
      case ($urandom_range(0, 5))
         0: v = VW'($urandom_range(0, 100));
         1: v = ~VW'($urandom_range(0, 99));
         2: v = VW'($urandom) >> $urandom_range(0, VW - 1);
         3: begin
            case ($urandom_range(0, 3))
               0: v = {1'b1, {(VW-1){1'b0}}};
               1: v = {1'b0, {(VW-1){1'b1}}};
               2: v = '1;
               default: v = '0;
            endcase
         end
         default: v = VW'($urandom);
      endcase
      return v;
   endfunction

   // Check each strobed character against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_character));
         end else begin
            next_char = expected_text.pop_front();
            if (rsp_character !== next_char.code) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, next_char.code));
            end
            if (rsp_final_char !== next_char.last) begin
               report_mismatch($sformatf("final flag %b, expected %b",
                                         rsp_final_char, next_char.last));
            end
         end
         char_count++;
      end
   end

   // Base ten straight out of reset: zero, signs and the word extremes
   task automatic test_decimal_after_reset();
      send_number(VW'(0));
      send_number(VW'(1));
      send_number('1);
      send_number(VW'(9));
      send_number(VW'(10));
      send_number(-VW'(10));
      send_number({1'b0, {(VW-1){1'b1}}});
      send_number({1'b1, {(VW-1){1'b0}}});
   endtask

   // Radix extremes, including clamping of out-of-range register values
   task automatic test_radix_extremes();
      write_radix(ita_pkg::RADIX_MIN);
      send_number(VW'(0));
      send_number(VW'(1));
      send_number('1);
      send_number({1'b1, {(VW-1){1'b0}}});
      write_radix(ita_pkg::RADIX_MAX);
      send_number('1);
      send_number(VW'(35));
      send_number(VW'(36));
      send_number({1'b0, {(VW-1){1'b1}}});
      // below two acts as base two, above thirty-six as base thirty-six
      write_radix(6'd0);
      send_number(VW'(5));
      write_radix(6'd1);
      send_number(VW'(6));
      write_radix(6'd37);
      send_number(VW'(35));
      write_radix(6'd63);
      send_number(VW'(36));
      // only base ten prints a sign
      write_radix(6'd16);
      send_number(VW'(32'hdeadbeef));
      send_number(-VW'(10));
   endtask

   // Random values across several radix settings, one phase without sender gaps
   task automatic test_random_values();
      logic [ita_pkg::RADIX_W-1:0] phase_radix[7];
      int p;
      int i;
      phase_radix[0] = ita_pkg::DECIMAL_BASE;
      phase_radix[1] = ita_pkg::RADIX_MIN;
      phase_radix[2] = ita_pkg::RADIX_MAX;
      phase_radix[3] = ita_pkg::RADIX_W'($urandom_range(3, 35));
      phase_radix[4] = ita_pkg::RADIX_W'($urandom_range(0, 63));
      phase_radix[5] = ita_pkg::RADIX_W'($urandom_range(0, 63));
      phase_radix[6] = ita_pkg::RADIX_W'($urandom_range(3, 35));
      for (p = 0; p < 7; p++) begin
         write_radix(phase_radix[p]);
         quiet_sender = (p == 3);
         for (i = 0; i < 23; i++) begin
            // now and then stop sending until the block has emptied
            if ($urandom_range(0, 49) == 0) begin
               wait_drained();
            end
            send_number(random_value());
         end
      end
      quiet_sender = 1'b0;
   endtask

   // Sequence the tests and give the verdict
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_decimal_after_reset();
      test_radix_extremes();
      test_random_values();
      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
